/* rtl/core/slg_pkg.sv */
// Package for the stream lifecycle guard: widths, codes and shared types.
package slg_pkg;

  // Field and counter widths.
  localparam int unsigned CmdWidth    = 4;
  localparam int unsigned GenWidth    = 32;
  localparam int unsigned SeqWidth    = 32;
  localparam int unsigned PhaseWidth  = 3;
  localparam int unsigned StatusWidth = 3;

  typedef logic [CmdWidth-1:0] cmd_t;
  typedef logic [GenWidth-1:0] gen_t;
  typedef logic [SeqWidth-1:0] seq_t;

  // Command codes carried by an input transfer.
  typedef enum logic [CmdWidth-1:0] {
    CMD_BEGIN      = 4'd0,
    CMD_REARM      = 4'd1,
    CMD_COMMIT     = 4'd2,
    CMD_ABORT      = 4'd3,
    CMD_CLAIM_STOP = 4'd4,
    CMD_FINISH     = 4'd5,
    CMD_RETRY      = 4'd6,
    CMD_POISON     = 4'd7,
    CMD_SNAPSHOT   = 4'd8
  } cmd_e;

  // Lifecycle phases.
  typedef enum logic [PhaseWidth-1:0] {
    PH_IDLE     = 3'd0,
    PH_STARTING = 3'd1,
    PH_RUNNING  = 3'd2,
    PH_STOPPING = 3'd3,
    PH_LOST     = 3'd4
  } phase_e;

  // Result status codes.
  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 3'd0,
    ST_BUSY      = 3'd1,
    ST_RUNNING   = 3'd2,
    ST_DEAD      = 3'd3,
    ST_IDLE      = 3'd4,
    ST_WRONG_GEN = 3'd5,
    ST_REFUSED   = 3'd6
  } status_e;

  // Architectural state of the guard.
  typedef struct packed {
    phase_e phase;
    phase_e prior;
    gen_t   cur_gen;
    gen_t   next_gen;
    seq_t   seq;
  } state_t;

  // One result item.
  typedef struct packed {
    status_e status;
    gen_t    gen;
    phase_e  phase;
    seq_t    seq;
  } result_t;

endpackage

/* rtl/core/slg_if.sv */
// Valid/ready channel interfaces for commands and results.
interface slg_cmd_if;
  import slg_pkg::*;

  logic valid;
  logic ready;
  cmd_t command;
  gen_t requested_gen;

  modport source (output valid, output command, output requested_gen, input ready);
  modport sink (input valid, input command, input requested_gen, output ready);
endinterface

interface slg_res_if;
  import slg_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [StatusWidth-1:0]      status;
  gen_t                        gen_out;
  logic [PhaseWidth-1:0]       phase_out;
  seq_t                        seq_out;

  modport source (output valid, output status, output gen_out, output phase_out,
                  output seq_out, input ready);
  modport sink (input valid, input status, input gen_out, input phase_out,
                input seq_out, output ready);
endinterface

/* rtl/core/stream_lifecycle_guard_unit.sv */
// Top level of the stream lifecycle guard: input register, state and result register.
//
// The block takes one command per transfer on cmd_i (command, requested_gen)
// and returns exactly one result per command on res_o (status, gen_out,
// phase_out, seq_out). Both channels are valid/ready; a transfer happens on
// a rising edge where valid and ready are both high.
//
// A command is captured in the input register, evaluated against the
// lifecycle state combinationally, and its result is written to the result
// register together with the state update, which raises res_o.valid. The
// input register holds a command while a stalled result sits in the result
// register; one command is accepted every cycle while res_o.ready is high.
//
// When the receiver holds res_o.ready low, the result register holds its
// item and the input register can still take one more command; cmd_i.ready
// drops only when both are full, so no item is lost or repeated.
//
// Reset puts the phase and prior phase to idle, clears the current and next
// generation and the change sequence count, and empties both registers.
module stream_lifecycle_guard_unit (
  input logic       clk_i,
  input logic       rst_ni,
  slg_cmd_if.sink   cmd_i,
  slg_res_if.source res_o
);
  import slg_pkg::*;

  logic    in_valid_q;
  cmd_t    cmd_q;
  gen_t    req_q;
  logic    out_valid_q;
  result_t res_q;
  state_t  state_q;
  state_t  state_d;
  result_t res_d;
  logic    out_adv;
  logic    step_en;

  // Pipeline flow control.
  assign out_adv     = !out_valid_q || res_o.ready;
  assign step_en     = in_valid_q && out_adv;
  assign cmd_i.ready = !in_valid_q || out_adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      cmd_q <= cmd_i.command;
      req_q <= cmd_i.requested_gen;
    end
  end

  // Command evaluation.
  slg_step u_step (
    .cur_i (state_q),
    .cmd_i (cmd_q),
    .req_i (req_q),
    .nxt_o (state_d),
    .res_o (res_d)
  );

  // Lifecycle state, updated as each command retires into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, prior: PH_IDLE, cur_gen: '0, next_gen: '0, seq: '0};
    end else if (step_en) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.status    = res_q.status;
  assign res_o.gen_out   = res_q.gen;
  assign res_o.phase_out = res_q.phase;
  assign res_o.seq_out   = res_q.seq;

endmodule

/* rtl/core/slg_step.sv */
// Next-state and result logic for one command of the lifecycle guard.
module slg_step (
  input  slg_pkg::state_t  cur_i,
  input  slg_pkg::cmd_t    cmd_i,
  input  slg_pkg::gen_t    req_i,
  output slg_pkg::state_t  nxt_o,
  output slg_pkg::result_t res_o
);
  import slg_pkg::*;

  logic    bump;
  logic    zero_gen;
  status_e status;
  gen_t    gen_base;
  gen_t    gen_inc;

  // Generation minting: a zero counter counts as one, and the step skips zero.
  assign gen_base = (cur_i.next_gen == '0) ? gen_t'(1) : cur_i.next_gen;
  assign gen_inc  = (gen_base + gen_t'(1) == '0) ? gen_t'(1) : gen_base + gen_t'(1);

  // Command decode and guarded transitions.
  always_comb begin
    nxt_o    = cur_i;
    bump     = 1'b0;
    zero_gen = 1'b0;
    status   = ST_REFUSED;
    unique case (cmd_i) inside
      CMD_BEGIN: begin
        if (cur_i.phase == PH_IDLE) begin
          nxt_o.prior = cur_i.phase;
          nxt_o.phase = PH_STARTING;
          bump        = 1'b1;
          status      = ST_OK;
        end else if (cur_i.phase == PH_RUNNING) begin
          status = ST_RUNNING;
        end else if (cur_i.phase == PH_LOST) begin
          status = ST_DEAD;
        end else begin
          status = ST_BUSY;
        end
      end
      CMD_REARM: begin
        if (cur_i.phase == PH_RUNNING) begin
          nxt_o.prior = cur_i.phase;
          nxt_o.phase = PH_STARTING;
          bump        = 1'b1;
          status      = ST_OK;
        end
      end
      CMD_COMMIT: begin
        if (cur_i.phase == PH_STARTING) begin
          nxt_o.cur_gen  = gen_base;
          nxt_o.next_gen = gen_inc;
          nxt_o.phase    = PH_RUNNING;
          bump           = 1'b1;
          status         = ST_OK;
        end else begin
          zero_gen = 1'b1;
        end
      end
      CMD_ABORT: begin
        if (cur_i.phase == PH_STARTING) begin
          nxt_o.phase = cur_i.prior;
          bump        = 1'b1;
          status      = ST_OK;
        end
      end
      CMD_CLAIM_STOP: begin
        if (cur_i.phase == PH_IDLE) begin
          status = ST_IDLE;
        end else if (cur_i.phase == PH_LOST) begin
          status = ST_DEAD;
        end else if (cur_i.phase != PH_RUNNING || cur_i.cur_gen == '0) begin
          status = ST_BUSY;
        end else if (req_i != '0 && req_i != cur_i.cur_gen) begin
          status = ST_WRONG_GEN;
        end else begin
          nxt_o.phase = PH_STOPPING;
          bump        = 1'b1;
          status      = ST_OK;
        end
      end
      CMD_FINISH, CMD_RETRY, CMD_POISON: begin
        if (cur_i.phase == PH_STOPPING) begin
          if (cmd_i == CMD_FINISH) begin
            nxt_o.phase = PH_IDLE;
          end else if (cmd_i == CMD_RETRY) begin
            nxt_o.phase = PH_RUNNING;
          end else begin
            nxt_o.phase = PH_LOST;
          end
          bump   = 1'b1;
          status = ST_OK;
        end
      end
      CMD_SNAPSHOT: begin
        status = ST_OK;
      end
      default: begin
        status = ST_REFUSED;
      end
    endcase
    if (bump) begin
      nxt_o.seq = cur_i.seq + seq_t'(1);
    end
  end

  // The result reports the state after the step, with the generation forced to zero on a refused commit.
  always_comb begin
    res_o.status = status;
    res_o.gen    = zero_gen ? '0 : nxt_o.cur_gen;
    res_o.phase  = nxt_o.phase;
    res_o.seq    = nxt_o.seq;
  end

endmodule

/* rtl/core/slg_checker.sv */
// Port-level checks for the stream lifecycle guard, bound to the top level.
module slg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           res_valid_i,
  input logic                           res_ready_i,
  input logic [slg_pkg::StatusWidth-1:0] status_i,
  input slg_pkg::gen_t                  gen_i,
  input logic [slg_pkg::PhaseWidth-1:0] phase_i,
  input slg_pkg::seq_t                  seq_i
);
  import slg_pkg::*;

  logic res_xfer;
  logic seen_q;
  seq_t last_seq_q;

  assign res_xfer = res_valid_i && res_ready_i;

  // Remember the sequence count of the last result transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_seq_q <= '0;
    end else if (res_xfer) begin
      seen_q     <= 1'b1;
      last_seq_q <= seq_i;
    end
  end

  // A stalled result stays offered with the same payload.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(status_i) &&
    $stable(gen_i) && $stable(phase_i) && $stable(seq_i))
    else $error("result changed while stalled");

  // The change count moves by at most one between results.
  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_xfer && seen_q |-> seq_i == last_seq_q || seq_i == last_seq_q + seq_t'(1))
    else $error("change sequence skipped");

  // Only an accepted command changes the sequence count.
  a_seq_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_xfer && seen_q && seq_i != last_seq_q |-> status_i == ST_OK)
    else $error("sequence changed on a refused command");

  // Running carries a minted generation on every result but a refused one, since a refused commit reports zero.
  a_run_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_xfer && phase_i == PH_RUNNING && status_i != ST_REFUSED |-> gen_i != '0)
    else $error("running without a generation");

endmodule

bind stream_lifecycle_guard_unit slg_checker u_slg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .status_i    (res_o.status),
  .gen_i       (res_o.gen_out),
  .phase_i     (res_o.phase_out),
  .seq_i       (res_o.seq_out)
);
